// ----- hdl/word_frequency_table_defines.svh -----
// Assertion macros used by the word frequency table RTL.
`ifndef WORD_FREQUENCY_TABLE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/wft_pkg.sv -----
// Shared constants and types of the word frequency table.
package wft_pkg;

  localparam int ENTRIES  = 16;
  localparam int WORD_LEN = 32;

  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 5;
  localparam int SLOT_W  = 4;
  localparam int FREQ_W  = 16;
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W  = $clog2(ENTRIES + 1);
  localparam int POS_W   = $clog2(WORD_LEN + 2);
  localparam int ADDR_W  = $clog2(WORD_LEN);
  localparam int LEN_W   = $clog2(WORD_LEN + 1);

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Kind of work carried into the table stage.
  localparam logic KIND_LETTER = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              trunc;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ----- hdl/wft_char_if.sv -----
// Character input channel of the word frequency table.
interface wft_char_if;
  logic                      valid;
  logic                      ready;
  logic [wft_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ----- hdl/wft_result_if.sv -----
// Result channel of the word frequency table.
interface wft_result_if;
  logic                      valid;
  logic                      ready;
  logic [wft_pkg::SLOT_W-1:0] slot;
  logic [wft_pkg::FREQ_W-1:0] frequency;
  logic                      is_new;
  logic                      dropped;
  logic                      truncated;
  logic                      too_many;

  modport source (output valid, output slot, output frequency, output is_new,
                  output dropped, output truncated, output too_many, input ready);
  modport sink (input valid, input slot, input frequency, input is_new,
                input dropped, input truncated, input too_many, output ready);
endinterface

// ----- hdl/word_frequency_table.sv -----
// Word frequency table: counts case-folded words of a byte stream.
//
// Channels: chars carries one byte per transaction (valid/ready). ASCII letters
// build the current word, folded to lower case; any other byte ends a word that
// has at least one letter. results carries one transaction per finished word:
// the table slot, its count after the update (saturating), and the flags
// is_new, dropped, truncated (more than WORD_LEN letters) and too_many (sticky).
// Separators with no pending word and letters produce no result.
//
// Throughput: one byte per cycle while chars.ready is high. Each letter is
// compared against every stored entry at once; the stored letters live in one
// RAM bank per entry, all read at the current letter position, so a letter's
// compare happens in the cycle after it is taken. The stage register takes the
// terminating byte, and the result register is loaded from it once the result
// register is empty or its transaction is being taken, which raises results.valid.
// Reset (synchronous, rst high) empties the table, clears the current word and
// the too-many flag; the stores need no clearing pass.
// Receiver stall: the result register holds its transaction; letters keep
// flowing, and chars.ready drops only while a finished word waits for it.
module word_frequency_table (
  input  logic         clk,
  input  logic         rst,
  wft_char_if.sink     chars,
  wft_result_if.source results
);

  wft_pkg::stage_t  stage;
  wft_pkg::rd_req_t rd_req;
  logic             advance;

  // Classify bytes, track letter position, issue store reads.
  wft_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .stage   (stage),
    .rd_req  (rd_req)
  );

  // Compare letters, look up finished words, update counts, hold the result.
  wft_table u_table (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .rd_req  (rd_req),
    .advance (advance),
    .results (results)
  );

endmodule

// ----- hdl/wft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/wft_front.sv -----
// Input stage: classify the byte, track the letter position, issue the store read.
module wft_front (
  input  logic             clk,
  input  logic             rst,
  wft_char_if.sink         chars,
  input  logic             advance,
  output wft_pkg::stage_t  stage,
  output wft_pkg::rd_req_t rd_req
);

  localparam logic [wft_pkg::CHAR_W-1:0] UPPER_A = 8'h41;
  localparam logic [wft_pkg::CHAR_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [wft_pkg::CHAR_W-1:0] LOWER_A = 8'h61;
  localparam logic [wft_pkg::CHAR_W-1:0] LOWER_Z = 8'h7A;

  logic                       accept;
  logic                       is_upper;
  logic                       is_lower;
  logic                       is_letter;
  logic                       room;
  logic                       trunc;
  logic [wft_pkg::CHAR_W-1:0] diff;
  logic [wft_pkg::POS_W-1:0]  pos;
  logic [wft_pkg::POS_W-1:0]  pos_next;
  wft_pkg::stage_t            item_next;

  assign chars.ready = advance;
  assign accept      = chars.valid && advance;

  assign is_upper  = (chars.char_in >= UPPER_A) && (chars.char_in <= UPPER_Z);
  assign is_lower  = (chars.char_in >= LOWER_A) && (chars.char_in <= LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign diff      = is_upper ? (chars.char_in - UPPER_A) : (chars.char_in - LOWER_A);
  assign room      = pos < wft_pkg::POS_W'(wft_pkg::WORD_LEN);
  assign trunc     = pos > wft_pkg::POS_W'(wft_pkg::WORD_LEN);

  assign rd_req.en   = accept && is_letter && room;
  assign rd_req.addr = pos[wft_pkg::ADDR_W-1:0];

  always_comb begin
    item_next.valid = accept && ((is_letter && room) || (!is_letter && (pos != '0)));
    item_next.kind  = is_letter ? wft_pkg::KIND_LETTER : wft_pkg::KIND_FINISH;
    item_next.code  = diff[wft_pkg::CODE_W-1:0];
    item_next.addr  = pos[wft_pkg::ADDR_W-1:0];
    item_next.len   = trunc ? wft_pkg::LEN_W'(wft_pkg::WORD_LEN) : pos[wft_pkg::LEN_W-1:0];
    item_next.trunc = trunc;

    pos_next = pos;
    if (accept) begin
      if (!is_letter) begin
        pos_next = '0;
      end else if (room) begin
        pos_next = pos + wft_pkg::POS_W'(1);
      end else begin
        pos_next = wft_pkg::POS_W'(wft_pkg::WORD_LEN + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      stage.valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (advance) begin
        stage <= item_next;
      end
    end
  end

endmodule

// ----- hdl/wft_table.sv -----
// Table stage: per-entry letter compare, word lookup, count update and result register.
`include "word_frequency_table_defines.svh"

module wft_table (
  input  logic             clk,
  input  logic             rst,
  input  wft_pkg::stage_t  stage,
  input  wft_pkg::rd_req_t rd_req,
  output logic             advance,
  wft_result_if.source     results
);

  logic [wft_pkg::CODE_W-1:0]  rd_code [wft_pkg::ENTRIES];
  logic [wft_pkg::LEN_W-1:0]   len_tab [wft_pkg::ENTRIES];
  logic [wft_pkg::FREQ_W-1:0]  cnt_tab [wft_pkg::ENTRIES];
  logic [wft_pkg::ENTRIES-1:0] match;
  logic [wft_pkg::ENTRIES-1:0] match_next;
  logic [wft_pkg::ENTRIES-1:0] hit;
  logic [wft_pkg::ENTRIES-1:0] wr_en;
  logic [wft_pkg::USED_W-1:0]  used;
  logic                        overflow;

  logic                        is_letter;
  logic                        fire;
  logic                        found;
  logic                        has_room;
  logic [wft_pkg::ENTRY_W-1:0] found_slot;
  logic [wft_pkg::ENTRY_W-1:0] new_slot;
  logic [wft_pkg::FREQ_W-1:0]  cnt_cur;
  logic [wft_pkg::FREQ_W-1:0]  cnt_inc;

  logic                        res_valid;
  logic [wft_pkg::SLOT_W-1:0]  res_slot;
  logic [wft_pkg::FREQ_W-1:0]  res_freq;
  logic                        res_new;
  logic                        res_dropped;
  logic                        res_trunc;
  logic                        res_too_many;

  // One letter store bank per entry, all read at the same position.
  for (genvar g = 0; g < wft_pkg::ENTRIES; g++) begin : g_bank
    assign wr_en[g] = is_letter && (used == wft_pkg::USED_W'(g));

    wft_ram #(
      .WIDTH (wft_pkg::CODE_W),
      .DEPTH (wft_pkg::WORD_LEN)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (stage.addr),
      .wr_data (stage.code),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_code[g])
    );
  end

  assign is_letter = stage.valid && (stage.kind == wft_pkg::KIND_LETTER);
  // Hold a finished word while the result register is occupied and not being taken.
  assign advance   = !(stage.valid && (stage.kind == wft_pkg::KIND_FINISH) &&
                       res_valid && !results.ready);
  assign fire      = stage.valid && (stage.kind == wft_pkg::KIND_FINISH) && advance;
  assign has_room  = used < wft_pkg::USED_W'(wft_pkg::ENTRIES);
  assign new_slot  = used[wft_pkg::ENTRY_W-1:0];

  always_comb begin
    for (int e = 0; e < wft_pkg::ENTRIES; e++) begin
      match_next[e] = match[e];
      if (wft_pkg::USED_W'(e) < used) begin
        if (!((wft_pkg::LEN_W'(stage.addr) < len_tab[e]) && (rd_code[e] == stage.code))) begin
          match_next[e] = 1'b0;
        end
      end
      hit[e] = (wft_pkg::USED_W'(e) < used) && match[e] && (len_tab[e] == stage.len);
    end

    found      = 1'b0;
    found_slot = '0;
    for (int e = wft_pkg::ENTRIES - 1; e >= 0; e--) begin
      if (hit[e]) begin
        found      = 1'b1;
        found_slot = wft_pkg::ENTRY_W'(e);
      end
    end

    cnt_cur = cnt_tab[found_slot];
    cnt_inc = (cnt_cur == wft_pkg::FREQ_MAX) ? cnt_cur : cnt_cur + wft_pkg::FREQ_W'(1);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (found) begin
        cnt_tab[found_slot] <= cnt_inc;
      end else if (has_room) begin
        cnt_tab[new_slot] <= wft_pkg::FREQ_W'(1);
        len_tab[new_slot] <= stage.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match     <= '1;
      used      <= '0;
      overflow  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (is_letter) begin
        match <= match_next;
      end
      if (fire) begin
        match        <= '1;
        res_valid    <= 1'b1;
        res_trunc    <= stage.trunc;
        res_new      <= 1'b0;
        res_dropped  <= 1'b0;
        res_too_many <= overflow;
        if (found) begin
          res_slot <= wft_pkg::SLOT_W'(found_slot);
          res_freq <= cnt_inc;
        end else if (has_room) begin
          res_slot <= wft_pkg::SLOT_W'(new_slot);
          res_freq <= wft_pkg::FREQ_W'(1);
          res_new  <= 1'b1;
          used     <= used + wft_pkg::USED_W'(1);
        end else begin
          res_slot     <= '0;
          res_freq     <= '0;
          res_dropped  <= 1'b1;
          res_too_many <= 1'b1;
          overflow     <= 1'b1;
        end
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign results.valid     = res_valid;
  assign results.slot      = res_slot;
  assign results.frequency = res_freq;
  assign results.is_new    = res_new;
  assign results.dropped   = res_dropped;
  assign results.truncated = res_trunc;
  assign results.too_many  = res_too_many;

  `WFT_ASSERT_NOW(a_used_bound, 1'b1, used <= wft_pkg::USED_W'(wft_pkg::ENTRIES), "entry count past table size")
  `WFT_ASSERT_NOW(a_new_count_one, res_valid && res_new, res_freq == wft_pkg::FREQ_W'(1), "new entry count not one")
  `WFT_ASSERT_NOW(a_drop_flags, res_valid && res_dropped, res_too_many && !res_new, "drop without too-many flag")
  `WFT_ASSERT_NEXT(a_overflow_sticky, overflow, overflow, "too-many flag cleared")
  `WFT_ASSERT_NOW(a_drop_when_full, $rose(overflow), used == wft_pkg::USED_W'(wft_pkg::ENTRIES), "drop with free entries")

endmodule

// ----- dv/word_frequency_table_test.sv -----
// Self-checking testbench of the word frequency table: byte stream in, word results out.
module word_frequency_table_test;
  import wft_pkg::*;

  // Byte codes the predictor and the stimulus both lean on.
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

  // Random part length in accepted bytes, and the vocabulary size limit.
  localparam int RANDOM_CHARS   = 1280;
  localparam int VOCAB_CAP      = 48;

  // One result transaction as seen on the results channel.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [FREQ_W-1:0] frequency;
    logic              is_new;
    logic              dropped;
    logic              truncated;
    logic              too_many;
  } word_result_t;

  // Mirrors the table letter by letter and queues the result each finished word is due.
  class word_scoreboard;
    logic [CODE_W-1:0] stored_letters [ENTRIES][WORD_LEN];
    int                stored_len [ENTRIES];
    logic [FREQ_W-1:0] hit_count [ENTRIES];
    bit                candidate [ENTRIES];
    int                fill;
    int                pos;
    bit                mid_word;
    bit                overflowed;
    word_result_t      due_results[$];
    int                errors;

    function new();
      fill       = 0;
      pos        = 0;
      mid_word   = 1'b0;
      overflowed = 1'b0;
      errors     = 0;
      foreach (candidate[e]) candidate[e] = 1'b1;
    endfunction

    static function bit is_alpha(logic [CHAR_W-1:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      logic [CODE_W-1:0] code;
      word_result_t      r;
      int                len;
      int                found;
      bit                trunc;
      if (is_alpha(c)) begin
        mid_word = 1'b1;
        // Letters past the word limit only mark the word as truncated.
        if (pos >= WORD_LEN) begin
          pos = WORD_LEN + 1;
          return;
        end
        code = CODE_W'((c | CASE_BIT) - CH_LOWER_A);
        for (int e = 0; e < fill; e++) begin
          if (!(pos < stored_len[e] && stored_letters[e][pos] == code)) candidate[e] = 1'b0;
        end
        if (fill < ENTRIES) stored_letters[fill][pos] = code;
        pos++;
        return;
      end
      if (!mid_word) return;

      trunc = pos > WORD_LEN;
      len   = trunc ? WORD_LEN : pos;
      found = -1;
      for (int e = 0; e < fill; e++) begin
        if (found < 0 && candidate[e] && stored_len[e] == len) found = e;
      end
      r = '0;
      if (found >= 0) begin
        if (hit_count[found] != FREQ_MAX) hit_count[found]++;
        r.slot      = SLOT_W'(found);
        r.frequency = hit_count[found];
      end else if (fill < ENTRIES) begin
        stored_len[fill] = len;
        hit_count[fill]  = 1;
        r.slot           = SLOT_W'(fill);
        r.frequency      = 1;
        r.is_new         = 1'b1;
        fill++;
      end else begin
        r.dropped  = 1'b1;
        overflowed = 1'b1;
      end
      r.truncated = trunc;
      r.too_many  = overflowed;
      due_results.push_back(r);

      pos      = 0;
      mid_word = 1'b0;
      foreach (candidate[e]) candidate[e] = 1'b1;
    endfunction

    function void check_result(word_result_t got);
      word_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing due: slot %0d freq %0d new %b drop %b trunc %b many %b",
                   got.slot, got.frequency, got.is_new, got.dropped, got.truncated,
                   got.too_many);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at %0t", $time);
          $display("  expected slot %0d freq %0d new %b drop %b trunc %b many %b",
                   want.slot, want.frequency, want.is_new, want.dropped, want.truncated,
                   want.too_many);
          $display("  actual   slot %0d freq %0d new %b drop %b trunc %b many %b",
                   got.slot, got.frequency, got.is_new, got.dropped, got.truncated,
                   got.too_many);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  wft_char_if   chars_if ();
  wft_result_if results_if ();

  word_frequency_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  word_scoreboard sb = new();

  // When set, both sides run back to back with no idle cycles.
  bit no_idle = 1'b0;
  int chars_taken = 0;

  // Words already sent, lower case, kept so that later words hit the table.
  string vocab[$];

  // Opening bytes: both cases at the letter range edges, neighbors of the
  // letter ranges as separators, NUL, 0x7F, 0x80, 0xFF, and separators with no word.
  logic [CHAR_W-1:0] opening_bytes[$] = '{
    8'h41, 8'h00, 8'h61, 8'hFF, 8'h5A, 8'h7A, 8'h5B, 8'h7A, 8'h5A, 8'h40,
    8'h60, 8'h7B, 8'h62, 8'h80, 8'h42, 8'h41, 8'h7F, 8'h61, 8'h62, 8'h30
  };

  always #6 clk = ~clk;

  // Drop valid for a random gap, then offer the byte until it is taken.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid   <= 1'b1;
    chars_if.char_in <= c;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    sb.note_char(c);
    chars_taken++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_separator();
    logic [CHAR_W-1:0] s;
    do s = CHAR_W'($urandom_range(0, 255)); while (word_scoreboard::is_alpha(s));
    return s;
  endfunction

  function automatic string rand_word(int n);
    string w;
    w = "";
    for (int i = 0; i < n; i++) begin
      w = {w, "a"};
      w[i] = byte'(CH_LOWER_A + $urandom_range(0, 25));
    end
    return w;
  endfunction

  // Send a lower case word with random case per letter, then one or a few separators.
  task automatic send_word(input string w);
    logic [CHAR_W-1:0] c;
    int                seps;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
      send_char(c);
    end
    seps = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
    repeat (seps) send_char(pick_separator());
  endtask

  // Drop valid and hold off until every due result has arrived.
  task automatic drain_results();
    chars_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: stall a random number of cycles per transaction, then take one.
  initial begin : result_sink
    int           stall;
    word_result_t got;
    results_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (results_if.valid !== 1'b1);
      got.slot      = results_if.slot;
      got.frequency = results_if.frequency;
      got.is_new    = results_if.is_new;
      got.dropped   = results_if.dropped;
      got.truncated = results_if.truncated;
      got.too_many  = results_if.too_many;
      sb.check_result(got);
    end
  end

  initial begin : main_seq
    int    start;
    int    roll;
    int    n;
    string w;
    string long_word;

    rst              <= 1'b1;
    chars_if.valid   <= 1'b0;
    chars_if.char_in <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: letter range edges, odd separators, words that are
    // prefixes or extensions of stored ones.
    foreach (opening_bytes[i]) send_char(opening_bytes[i]);
    vocab = '{"a", "zz", "b", "ba", "ab"};
    drain_results();

    // Long words: a truncated word, a second one sharing its first WORD_LEN
    // letters, exactly WORD_LEN letters of it, and one letter short of that.
    long_word = rand_word(WORD_LEN + 8);
    send_word(long_word);
    send_word({long_word.substr(0, WORD_LEN - 1), rand_word(5)});
    send_word(long_word.substr(0, WORD_LEN - 1));
    send_word(long_word.substr(0, WORD_LEN - 2));
    vocab.push_back(long_word);
    vocab.push_back(long_word.substr(0, WORD_LEN - 2));
    drain_results();

    // Random part: mostly known words so the table sees hits, plus mutated and
    // fresh words that fill it and then get dropped, plus raw byte noise.
    start = chars_taken;
    while (chars_taken - start < RANDOM_CHARS) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_word(vocab[$urandom_range(0, vocab.size() - 1)]);
      end else if (roll < 88) begin
        if (roll < 65) begin
          w = vocab[$urandom_range(0, vocab.size() - 1)];
          if (w.len() > 1 && $urandom_range(0, 1)) w = w.substr(0, w.len() - 2);
          else w = {w, rand_word(1)};
        end else begin
          n = $urandom_range(0, 19);
          if (n < 16) n = $urandom_range(1, 6);
          else if (n < 19) n = $urandom_range(7, 20);
          else n = $urandom_range(WORD_LEN - 4, WORD_LEN + 8);
          w = rand_word(n);
        end
        if (vocab.size() < VOCAB_CAP) vocab.push_back(w);
        send_word(w);
      end else begin
        repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    // End: make sure a trailing word is closed, wait for all due results,
    // then let a few more cycles pass to catch any stray transaction.
    send_char(CH_SPACE);
    drain_results();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("word_frequency_table_test: clean");
    end else begin
      $display("word_frequency_table_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #24000000;
    $display("word_frequency_table_test: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/wft_pkg.sv
hdl/wft_char_if.sv
hdl/wft_result_if.sv
hdl/wft_ram.sv
hdl/wft_front.sv
hdl/wft_table.sv
hdl/word_frequency_table.sv
dv/word_frequency_table_test.sv
